>>> rtl/stereo_level_meter_k_weighted_macros.svh
// Assertion helpers for the stereo level meter
`ifndef STEREO_LEVEL_METER_K_WEIGHTED_MACROS_SVH
`define STEREO_LEVEL_METER_K_WEIGHTED_MACROS_SVH
// assert an implication on every clock unless reset is low
`define SLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert an implication including the reset cycles
`define SLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the stereo level meter.
// ----------------------------------------------------------------------------
package slm_pkg;
  localparam int StagesDef      = 4;
  localparam int TracksDef      = 16;
  localparam int HoldWindowsDef = 8;

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_PUBLISH = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TRACK  = 2'd1;
  localparam logic [1:0] CFG_WSTAGE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         stage;
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         out_stage;
    logic [23:0]        held_peak;
    logic [62:0]        energy;
    logic [62:0]        weighted_energy;
    logic signed [47:0] mid_total;
    logic [31:0]        sample_count;
    logic               last_record;
  } out_word_t;

  // coefficient table, Q4.30 style integers (shelf 0..4, high-pass 5..9)
  function automatic logic signed [33:0] coef(input logic [3:0] i);
    logic signed [33:0] c;
    begin
      unique case (i)
        4'd0: c = 34'sd1648327767;
        4'd1: c = -34'sd2890186777;
        4'd2: c = 34'sd1286764482;
        4'd3: c = -34'sd1815331590;
        4'd4: c = 34'sd786495238;
        4'd5: c = 34'sd1073741824;
        4'd6: c = -34'sd2147483648;
        4'd7: c = 34'sd1073741824;
        4'd8: c = -34'sd2136797179;
        4'd9: c = 34'sd1063081984;
        default: c = '0;
      endcase
      return c;
    end
  endfunction
endpackage

>>> rtl/slm_if.sv
// ----------------------------------------------------------------------------
// slm_if
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface slm_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/stereo_level_meter_k_weighted.sv
// ----------------------------------------------------------------------------
// stereo_level_meter_k_weighted
// Per-stage stereo level meter with a K-weighted energy path.
// ----------------------------------------------------------------------------
// Sample path: accept, accumulate; on the weighted stage also ten multiply-and-sum
//   passes through the shared 34x32 multiplier, two section closes and the
//   square; clear, unused and dropped words finish in the accept step.
// Publish: hold read, hold write and record output per stage in turn; one word in flight.
// Reset (rst_n low, synchronous) zeroes the configuration and control registers,
//   accumulators, filter history and the hold table valid bits.
module stereo_level_meter_k_weighted
  import slm_pkg::*;
#(
  parameter int STAGES       = StagesDef,
  parameter int TRACKS       = TracksDef,
  parameter int HOLD_WINDOWS = HoldWindowsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  slm_if.sink         in_ch,
  slm_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int HD = TRACKS * STAGES;
  localparam int HW = (HD > 1) ? $clog2(HD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_FMUL, S_FSUM, S_SQ, S_WACC, S_PRD, S_PWR, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic       en_r;
  logic [3:0] trk_r;
  logic [1:0] wst_r;

  // window statistics
  logic [23:0]        peak_r [STAGES];
  logic [62:0]        esum_r [STAGES];
  logic [62:0]        wsum_r;
  logic signed [47:0] msum_r [STAGES];
  logic [31:0]        cnt_r  [STAGES];
  logic signed [31:0] hist_r [8];

  // hold table: memory with valid bits
  logic [27:0]   hold_mem [HD];
  logic [HD-1:0] hold_vld_r;
  logic [27:0]   hold_q_r;
  logic          hold_qv_r;

  in_word_t           w_r;
  logic [SW-1:0]      st_r;
  logic [3:0]         k_r;       // filter tap / coefficient index
  logic signed [31:0] x_r;       // current biquad input
  logic signed [65:0] prod_r;
  logic signed [67:0] acc_r;
  logic signed [31:0] y_r;
  out_word_t          ow_r;
  logic               ov_r;

  logic hit;
  assign hit = (STAGES >= 4) || ({2'b0, in_ch.data.stage} < 4'(STAGES));

  // ---------------------------------------------------------------- datapath
  logic [23:0]        al, ar;
  logic signed [24:0] mid;
  logic [47:0]        sq_l, sq_r;
  logic [48:0]        esq;
  logic signed [31:0] mul_a;
  logic signed [65:0] mul_p;
  logic signed [65:0] term;
  logic signed [67:0] rnd;
  logic signed [31:0] ysat;
  logic [31:0]        ay;
  logic [63:0]        ysq;
  logic [63:0]        esum_n, wsum_n;
  logic signed [48:0] msum_n;
  logic [HW-1:0]      hidx;
  logic [23:0]        hpk;
  logic [3:0]         hage;
  logic [23:0]        npk;
  logic [3:0]         nage;
  logic [4:0]         age1;

  always_comb begin
    al   = w_r.left_sample[23]  ? 24'(-w_r.left_sample)  : 24'(w_r.left_sample);
    ar   = w_r.right_sample[23] ? 24'(-w_r.right_sample) : 24'(w_r.right_sample);
    mid  = 25'(w_r.left_sample) + 25'(w_r.right_sample);
    sq_l = al * al;
    sq_r = ar * ar;
    esq  = ({1'b0, sq_l} + {1'b0, sq_r});
    esum_n = {1'b0, esum_r[st_r]} + {16'b0, esq[48:1]};
    msum_n = 49'(msum_r[st_r]) + 49'(mid >>> 1);
    // shared multiplier operand: x, x1, x2, y1, y2 for the current section
    unique case (k_r)
      4'd0, 4'd5: mul_a = x_r;
      4'd1:       mul_a = hist_r[0];
      4'd2:       mul_a = hist_r[1];
      4'd3:       mul_a = hist_r[2];
      4'd4:       mul_a = hist_r[3];
      4'd6:       mul_a = hist_r[4];
      4'd7:       mul_a = hist_r[5];
      4'd8:       mul_a = hist_r[6];
      4'd9:       mul_a = hist_r[7];
      default:    mul_a = '0;
    endcase
    mul_p = coef(k_r) * 66'(mul_a);
    term  = prod_r >>> 4;
    rnd   = (acc_r + 68'sd33554432) >>> 26;
    if (rnd > 68'sd2147483647)       ysat = 32'sh7fffffff;
    else if (rnd < -68'sd2147483648) ysat = 32'sh80000000;
    else                             ysat = 32'(rnd);
    ay     = y_r[31] ? 32'(-y_r) : 32'(y_r);
    ysq    = ay * ay;
    wsum_n = {1'b0, wsum_r} + {2'b0, ysq[63:2]};
    hidx   = HW'(trk_r * STAGES) + HW'(st_r);
    hpk    = hold_qv_r ? hold_q_r[27:4] : '0;
    hage   = hold_qv_r ? hold_q_r[3:0]  : '0;
    age1   = {1'b0, hage} + 5'd1;
    if (peak_r[st_r] >= hpk) begin
      npk = peak_r[st_r]; nage = '0;
    end else if ({1'b0, age1[3:0]} >= 5'(HOLD_WINDOWS)) begin
      npk = peak_r[st_r]; nage = '0;
    end else begin
      npk = hpk; nage = age1[3:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = ow_r;

  // hold memory port
  always_ff @(posedge clk) begin
    if (state_r == S_PRD) hold_q_r <= hold_mem[hidx];
    if (state_r == S_PWR) hold_mem[hidx] <= {npk, nage};
  end

  // ----------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      en_r       <= 1'b0;
      trk_r      <= '0;
      wst_r      <= '0;
      ov_r       <= 1'b0;
      hold_vld_r <= '0;
      hold_qv_r  <= 1'b0;
      wsum_r     <= '0;
      for (int i = 0; i < STAGES; i++) begin
        peak_r[i] <= '0; esum_r[i] <= '0; msum_r[i] <= '0; cnt_r[i] <= '0;
      end
      for (int i = 0; i < 8; i++) hist_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE: en_r  <= cfg_data[0];
          CFG_TRACK:  trk_r <= cfg_data;
          CFG_WSTAGE: wst_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            w_r  <= in_ch.data;
            // a publish walks the stages from the first one
            st_r <= (in_ch.data.mode == MODE_PUBLISH) ? '0 : SW'(in_ch.data.stage);
            unique case (mode_t'(in_ch.data.mode))
              MODE_SAMPLE:  if (en_r && hit) state_r <= S_ACC;
              MODE_PUBLISH: begin
                if ({28'b0, trk_r} < 32'(TRACKS)) state_r <= S_PRD;
              end
              MODE_CLEAR: begin
                wsum_r <= '0;
                for (int i = 0; i < STAGES; i++) begin
                  peak_r[i] <= '0; esum_r[i] <= '0; msum_r[i] <= '0; cnt_r[i] <= '0;
                end
                for (int i = 0; i < 8; i++) hist_r[i] <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ACC: begin
          if (al > peak_r[st_r] || ar > peak_r[st_r])
            peak_r[st_r] <= (al > ar) ? al : ar;
          esum_r[st_r] <= esum_n[63] ? '1 : esum_n[62:0];
          if (msum_n > 49'sh0_7fff_ffff_ffff)      msum_r[st_r] <= 48'sh7fff_ffff_ffff;
          else if (msum_n < -49'sh0_8000_0000_0000) msum_r[st_r] <= 48'sh8000_0000_0000;
          else                                      msum_r[st_r] <= 48'(msum_n);
          if (cnt_r[st_r] != '1) cnt_r[st_r] <= cnt_r[st_r] + 32'd1;
          if ({30'b0, wst_r} == 32'(st_r) || (SW < 2 && wst_r == 2'(st_r))) begin
            x_r     <= 32'(mid);
            k_r     <= '0;
            acc_r   <= '0;
            state_r <= S_FMUL;
          end else state_r <= S_IDLE;
        end
        S_FMUL: begin
          prod_r  <= mul_p;
          state_r <= S_FSUM;
        end
        S_FSUM: begin
          // feedback taps are subtracted
          if (k_r == 4'd3 || k_r == 4'd4 || k_r == 4'd8 || k_r == 4'd9)
            acc_r <= acc_r - 68'(term);
          else
            acc_r <= acc_r + 68'(term);
          if (k_r == 4'd4 || k_r == 4'd9) state_r <= S_SQ;
          else begin
            k_r <= k_r + 4'd1; state_r <= S_FMUL;
          end
        end
        S_SQ: begin
          // close one section: shift history, take output
          if (k_r == 4'd4) begin
            hist_r[1] <= hist_r[0]; hist_r[0] <= x_r;
            hist_r[3] <= hist_r[2]; hist_r[2] <= ysat;
            x_r <= ysat; acc_r <= '0; k_r <= 4'd5; state_r <= S_FMUL;
          end else begin
            hist_r[5] <= hist_r[4]; hist_r[4] <= x_r;
            hist_r[7] <= hist_r[6]; hist_r[6] <= ysat;
            y_r <= ysat; state_r <= S_WACC;
          end
        end
        S_WACC: begin
          wsum_r  <= wsum_n[63] ? '1 : wsum_n[62:0];
          state_r <= S_IDLE;
        end
        S_PRD: begin
          hold_qv_r <= hold_vld_r[hidx];
          if (!ov_r) state_r <= S_PWR;
        end
        S_PWR: begin
          hold_vld_r[hidx]     <= 1'b1;
          ow_r.out_stage       <= 2'(st_r);
          ow_r.held_peak       <= npk;
          ow_r.energy          <= esum_r[st_r];
          ow_r.weighted_energy <= ({30'b0, wst_r} == 32'(st_r)) ? wsum_r : '0;
          ow_r.mid_total       <= msum_r[st_r];
          ow_r.sample_count    <= cnt_r[st_r];
          ow_r.last_record     <= (32'(st_r) == STAGES - 1);
          ov_r                 <= 1'b1;
          state_r              <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r) begin
            if (32'(st_r) == STAGES - 1) state_r <= S_IDLE;
            else begin
              st_r <= st_r + SW'(1); state_r <= S_PRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/slm_checker.sv
// ----------------------------------------------------------------------------
// slm_checker
// Port-level checks on the stereo level meter.
// ----------------------------------------------------------------------------
`include "stereo_level_meter_k_weighted_macros.svh"
module slm_checker
  import slm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      in_valid,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  `SLM_ASSERT(out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output dropped")
  `SLM_ASSERT(busy_out, out_valid |-> !in_ready, "input taken while record pending")
  `SLM_ASSERT(in_wait, in_valid && !in_ready |=> in_valid, "input word withdrawn before accept")
  `SLM_ASSERT_ALWAYS(rst_quiet, !rst_n |=> !out_valid, "output after reset")
endmodule

bind stereo_level_meter_k_weighted slm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .in_valid(in_ch.valid),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

>>> test/stereo_level_meter_k_weighted_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_level_meter_k_weighted_tb
// Drives sample, publish, clear and unused words into the level meter and
// checks every published record against a cycle-free model of the meter,
// including the K-weighting filter and the peak hold table.
// ----------------------------------------------------------------------------
module stereo_level_meter_k_weighted_tb;
  import slm_pkg::*;

  localparam int  NSTAGE      = 4;
  localparam int  NTRACK      = 16;
  localparam int  HOLD_LIMIT  = 8;
  localparam int  DRAIN_WAIT  = 40;      // longest sample path is the weighted stage
  localparam int  CYCLE_LIMIT = 600000;
  localparam logic [63:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint MID_MAX = 64'sd140737488355327;
  localparam longint MID_MIN = -64'sd140737488355328;
  localparam logic signed [23:0] FS_NEG = 24'sh800000;
  localparam logic signed [23:0] FS_POS = 24'sh7FFFFF;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  slm_if #(.word_t(in_word_t))  in_bus ();
  slm_if #(.word_t(out_word_t)) out_bus ();

  stereo_level_meter_k_weighted uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock: 2 ns period
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Register copy kept by the predictor
  logic       meter_on;
  logic [3:0] track_sel;
  logic [1:0] kw_stage_sel;

  // Window statistics and hold table of the predictor
  logic [23:0]        win_peak [NSTAGE];
  logic [63:0]        pow_acc  [NSTAGE];
  logic [63:0]        kw_pow_acc;
  logic signed [47:0] mid_acc  [NSTAGE];
  logic [31:0]        n_seen   [NSTAGE];
  logic signed [31:0] kw_hist  [8];      // shelf x1 x2 y1 y2, high-pass x1 x2 y1 y2
  logic [23:0]        hold_pk  [NTRACK*NSTAGE];
  logic [3:0]         hold_ag  [NTRACK*NSTAGE];

  in_word_t  pend_q[$];   // words waiting for the driver
  out_word_t rec_q[$];    // records the meter owes us

  int  tx_idle_pct;
  int  rx_idle_pct;
  int  fails;
  int  cycles;
  int  hold_left;
  bit  hold_go;
  bit  hold_used;
  logic in_taken;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > ENERGY_MAX) ? ENERGY_MAX : s;
  endfunction

  // One biquad section; base selects the history slice, hp the coefficient set
  function automatic logic signed [31:0] biquad_step(int base, bit hp,
                                                     logic signed [31:0] x);
    longint k[5];
    longint acc;
    longint t;
    logic signed [31:0] y;
    for (int j = 0; j < 5; j++) k[j] = longint'(coef(hp ? 4'(j + 5) : 4'(j)));
    acc = ((k[0] * longint'(x)) >>> 4)
        + ((k[1] * longint'(kw_hist[base])) >>> 4)
        + ((k[2] * longint'(kw_hist[base+1])) >>> 4)
        - ((k[3] * longint'(kw_hist[base+2])) >>> 4)
        - ((k[4] * longint'(kw_hist[base+3])) >>> 4);
    t = (acc + (64'sd1 <<< 25)) >>> 26;
    if (t > 64'sd2147483647)       y = 32'sh7FFFFFFF;
    else if (t < -64'sd2147483648) y = 32'sh80000000;
    else                           y = t[31:0];
    kw_hist[base+1] = kw_hist[base];
    kw_hist[base]   = x;
    kw_hist[base+3] = kw_hist[base+2];
    kw_hist[base+2] = y;
    return y;
  endfunction

  function automatic void clear_window();
    for (int s = 0; s < NSTAGE; s++) begin
      win_peak[s] = '0;
      pow_acc[s]  = '0;
      mid_acc[s]  = '0;
      n_seen[s]   = '0;
    end
    kw_pow_acc = '0;
    for (int i = 0; i < 8; i++) kw_hist[i] = '0;
  endfunction

  function automatic void add_sample(int s, logic signed [23:0] l24,
                                     logic signed [23:0] r24);
    longint l, r, al, ar, m, ay;
    logic signed [31:0] y;
    l  = l24;
    r  = r24;
    al = (l < 0) ? -l : l;
    ar = (r < 0) ? -r : r;
    if (((al > ar) ? al : ar) > longint'(win_peak[s]))
      win_peak[s] = (al > ar) ? al[23:0] : ar[23:0];
    pow_acc[s] = add_sat(pow_acc[s], (al * al + ar * ar) >> 1);
    m = longint'(mid_acc[s]) + ((l + r) >>> 1);
    if (m > MID_MAX) m = MID_MAX;
    if (m < MID_MIN) m = MID_MIN;
    mid_acc[s] = m[47:0];
    if (s == kw_stage_sel) begin
      y  = biquad_step(4, 1'b1, biquad_step(0, 1'b0, 32'(l + r)));
      ay = (y < 0) ? -longint'(y) : longint'(y);
      kw_pow_acc = add_sat(kw_pow_acc, (ay * ay) >> 2);
    end
    if (n_seen[s] != 32'hFFFF_FFFF) n_seen[s] = n_seen[s] + 1;
  endfunction

  // Work out what one accepted word owes; publish pushes one record per stage
  function automatic void predict_word(in_word_t w);
    out_word_t rec;
    int i;
    case (mode_t'(w.mode))
      MODE_SAMPLE: begin
        if (meter_on) add_sample(w.stage, w.left_sample, w.right_sample);
      end
      MODE_PUBLISH: begin
        for (int s = 0; s < NSTAGE; s++) begin
          i = track_sel * NSTAGE + s;
          if (win_peak[s] >= hold_pk[i]) begin
            hold_pk[i] = win_peak[s];
            hold_ag[i] = '0;
          end else begin
            hold_ag[i] = hold_ag[i] + 1;   // 4-bit wrap
            if (hold_ag[i] >= HOLD_LIMIT) begin
              hold_pk[i] = win_peak[s];
              hold_ag[i] = '0;
            end
          end
          rec.out_stage       = 2'(s);
          rec.held_peak       = hold_pk[i];
          rec.energy          = pow_acc[s][62:0];
          rec.weighted_energy = (s == kw_stage_sel) ? kw_pow_acc[62:0] : '0;
          rec.mid_total       = mid_acc[s];
          rec.sample_count    = n_seen[s];
          rec.last_record     = (s == NSTAGE - 1);
          rec_q.push_back(rec);
        end
      end
      MODE_CLEAR: clear_window();
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want,
                                      logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
               want, got);
      fails++;
    end
  endfunction

  function automatic void check_record(out_word_t got);
    out_word_t want;
    if (rec_q.size() == 0) begin
      $display("%0t ns: unexpected record, expected none, actual %p", $time, got);
      fails++;
      return;
    end
    want = rec_q.pop_front();
    check_field("out_stage",       want.out_stage,       got.out_stage);
    check_field("held_peak",       want.held_peak,       got.held_peak);
    check_field("energy",          want.energy,          got.energy);
    check_field("weighted_energy", want.weighted_energy, got.weighted_energy);
    check_field("mid_total",       64'(want.mid_total),  64'(got.mid_total));
    check_field("sample_count",    want.sample_count,    got.sample_count);
    check_field("last_record",     want.last_record,     got.last_record);
  endfunction

  // Monitor: sample both handshakes at the rising edge; check before predicting
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_record(out_bus.data);
      if (in_bus.valid && in_bus.ready) predict_word(in_bus.data);
      in_taken <= in_bus.valid && in_bus.ready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver: advance to the next word once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_bus.data  <= pend_q.pop_front();
        in_bus.valid <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end
  end

  // Receiver: drop ready at random, and for the whole hold-off
  always @(negedge clk) begin
    out_bus.ready <= rst_n && hold_left == 0 && !(hold_go && !hold_used)
                     && $urandom_range(99) >= rx_idle_pct;
  end

  function automatic in_word_t make_word(mode_t m, int s, logic signed [23:0] l,
                                         logic signed [23:0] r);
    in_word_t w;
    w.mode         = m;
    w.stage        = 2'(s);
    w.left_sample  = l;
    w.right_sample = r;
    return w;
  endfunction

  function automatic logic signed [23:0] rand_level();
    case ($urandom_range(9))
      0: return FS_NEG;
      1: return FS_POS;
      2: return 24'($urandom_range(255)) - 24'sd128;   // near silence
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly samples with random content; publish, clear and the unused mode mixed in
  function automatic in_word_t rand_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) return make_word(MODE_SAMPLE, $urandom_range(3), rand_level(),
                                    rand_level());
    if (pick < 88) return make_word(MODE_PUBLISH, $urandom_range(3), rand_level(),
                                    rand_level());
    if (pick < 95) return make_word(MODE_CLEAR, $urandom_range(3), rand_level(),
                                    rand_level());
    return make_word(MODE_NONE, $urandom_range(3), rand_level(), rand_level());
  endfunction

  // Hold until the meter has nothing in flight, then let it settle
  task automatic wait_idle();
    while (pend_q.size() > 0 || in_bus.valid || rec_q.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: meter_on     = val[0];
      CFG_TRACK:  track_sel    = val;
      CFG_WSTAGE: kw_stage_sel = val[1:0];
      default: ;
    endcase
  endtask

  task automatic random_words(int n);
    for (int k = 0; k < n; k++) pend_q.push_back(rand_word());
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    fails         = 0;
    hold_go       = 1'b0;
    meter_on      = 1'b0;
    track_sel     = '0;
    kw_stage_sel  = '0;
    clear_window();
    for (int i = 0; i < NTRACK*NSTAGE; i++) begin
      hold_pk[i] = '0;
      hold_ag[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Disabled meter: samples drop, publish and clear still act
    pend_q.push_back(make_word(MODE_SAMPLE, 1, FS_POS, FS_NEG));
    pend_q.push_back(make_word(MODE_PUBLISH, 0, '0, '0));
    pend_q.push_back(make_word(MODE_CLEAR, 0, '0, '0));
    wait_idle();

    // Phase A: sender idles 21 percent, receiver 78 percent
    tx_idle_pct = 21;
    rx_idle_pct = 78;
    write_reg(CFG_ENABLE, 4'd1);
    write_reg(CFG_TRACK, 4'd0);
    write_reg(CFG_WSTAGE, 4'd0);
    // Full-scale extremes on every stage, the negative one included
    for (int s = 0; s < NSTAGE; s++) begin
      pend_q.push_back(make_word(MODE_SAMPLE, s, FS_NEG, FS_NEG));
      pend_q.push_back(make_word(MODE_SAMPLE, s, FS_POS, FS_NEG));
    end
    pend_q.push_back(make_word(MODE_SAMPLE, 0, FS_POS, FS_POS));
    pend_q.push_back(make_word(MODE_NONE, 2, FS_POS, FS_POS));
    pend_q.push_back(make_word(MODE_PUBLISH, 0, '0, '0));
    // Peak falls after a clear: the hold keeps it until the age runs out
    pend_q.push_back(make_word(MODE_CLEAR, 0, '0, '0));
    pend_q.push_back(make_word(MODE_SAMPLE, 3, 24'sd1000, -24'sd3));
    for (int k = 0; k < HOLD_LIMIT + 1; k++)
      pend_q.push_back(make_word(MODE_PUBLISH, 0, '0, '0));
    random_words(80);
    wait_idle();

    // Phase B: sender idles 78 percent, receiver 21 percent, top track
    tx_idle_pct = 78;
    rx_idle_pct = 21;
    write_reg(CFG_TRACK, 4'd15);
    write_reg(CFG_WSTAGE, 4'd3);
    random_words(90);
    wait_idle();

    // Phase C: no idling; long receiver stall while words keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_TRACK, 4'd7);
    write_reg(CFG_WSTAGE, 4'd2);
    hold_go = 1'b1;
    random_words(50);
    wait_idle();
    write_reg(CFG_WSTAGE, 4'd1);
    random_words(40);
    wait_idle();

    // Turn the meter off again: only publish and clear move state
    write_reg(CFG_ENABLE, 4'd0);
    random_words(20);
    wait_idle();

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
